>>> rtl/first_fit_heap_allocator_defines.svh
// assertion macros used by the checker file
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

`endif

>>> rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int unsigned MAX_SEGMENTS = 64;
    localparam int unsigned HEADER_BYTES = 12;

    localparam int unsigned IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned SIZE_W = 25;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned REQ_W  = 24;

    localparam logic [SIZE_W-1:0] ALIGN_MASK = ~(SIZE_W'(3));

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_LEN  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FREE_NX,
        S_SHUP,
        S_SPLIT_HI,
        S_SPLIT_LO,
        S_SHDN
    } state_t;

    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef enum logic [2:0] {
        RD_ZERO,
        RD_IDX1,
        RD_IDX2,
        RD_CNTM1,
        RD_SPM2,
        RD_SPP2
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_USED,
        WR_SHIFT,
        WR_SPLIT_HI,
        WR_SPLIT_LO,
        WR_FREE
    } wr_sel_t;

    typedef enum logic [2:0] {
        SP_HOLD,
        SP_LOAD_CNT,
        SP_LOAD_IDX1,
        SP_DEC,
        SP_INC
    } sp_op_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_CLR,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ONE,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_SCAN,
        ADDR_SAVED
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        rd_sel_t   rd_sel;
        wr_sel_t   wr_sel;
        sp_op_t    sp_op;
        idx_op_t   idx_op;
        cnt_op_t   cnt_op;
        logic      save_hit;
        logic      finish;
        status_t   res;
        addr_sel_t addr_sel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       null_free;
        logic       hit;
        logic       last;
        logic       split;
        logic       full;
        logic       shift_up;
        logic       shup_more;
        logic       merge;
        logic       shdn_need;
        logic       shdn_more;
    } sts_t;

endpackage

>>> rtl/ffha_ctrl.sv
module ffha_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  ffha_pkg::sts_t  sts,
    output logic            busy,
    output ffha_pkg::cmd_t  cmd
);

    ffha_pkg::state_t state_reg;
    ffha_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ffha_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ffha_pkg::S_DISPATCH;
                end
            end
            ffha_pkg::S_DISPATCH:
            begin
                state_next = ffha_pkg::S_IDLE;
                if ((sts.op == ffha_pkg::OP_ALLOC && !sts.count_zero) ||
                    (sts.op == ffha_pkg::OP_FREE && !sts.null_free && !sts.count_zero))
                begin
                    state_next = ffha_pkg::S_SCAN;
                end
            end
            ffha_pkg::S_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.op == ffha_pkg::OP_FREE)
                    begin
                        state_next = ffha_pkg::S_FREE_NX;
                    end
                    else if (sts.split && !sts.full)
                    begin
                        state_next = sts.shift_up ? ffha_pkg::S_SHUP : ffha_pkg::S_SPLIT_HI;
                    end
                    else
                    begin
                        state_next = ffha_pkg::S_IDLE;
                    end
                end
                else if (sts.last)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            ffha_pkg::S_FREE_NX:
            begin
                state_next = (sts.merge && sts.shdn_need) ? ffha_pkg::S_SHDN : ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_SHUP:
            begin
                if (!sts.shup_more)
                begin
                    state_next = ffha_pkg::S_SPLIT_HI;
                end
            end
            ffha_pkg::S_SPLIT_HI:
            begin
                state_next = ffha_pkg::S_SPLIT_LO;
            end
            ffha_pkg::S_SPLIT_LO:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_SHDN:
            begin
                if (!sts.shdn_more)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = ffha_pkg::RD_ZERO;
        cmd.wr_sel   = ffha_pkg::WR_NONE;
        cmd.sp_op    = ffha_pkg::SP_HOLD;
        cmd.idx_op   = ffha_pkg::IDX_HOLD;
        cmd.cnt_op   = ffha_pkg::CNT_HOLD;
        cmd.res      = ffha_pkg::ST_OK;
        cmd.addr_sel = ffha_pkg::ADDR_ZERO;
        case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                cmd.capture = start;
            end
            ffha_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    ffha_pkg::OP_INIT:
                    begin
                        cmd.wr_sel = ffha_pkg::WR_INIT;
                        cmd.cnt_op = ffha_pkg::CNT_ONE;
                        cmd.finish = 1'b1;
                    end
                    ffha_pkg::OP_ALLOC:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = ffha_pkg::ST_NOMEM;
                        end
                        else
                        begin
                            cmd.idx_op = ffha_pkg::IDX_CLR;
                        end
                    end
                    ffha_pkg::OP_FREE:
                    begin
                        if (sts.null_free)
                        begin
                            cmd.finish = 1'b1;
                        end
                        else if (sts.count_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = ffha_pkg::ST_UNKNOWN;
                        end
                        else
                        begin
                            cmd.idx_op = ffha_pkg::IDX_CLR;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            ffha_pkg::S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.save_hit = 1'b1;
                    if (sts.op == ffha_pkg::OP_FREE)
                    begin
                        cmd.rd_sel = ffha_pkg::RD_IDX1;
                    end
                    else if (sts.split)
                    begin
                        if (sts.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.res    = ffha_pkg::ST_FULL;
                        end
                        else if (sts.shift_up)
                        begin
                            cmd.sp_op  = ffha_pkg::SP_LOAD_CNT;
                            cmd.rd_sel = ffha_pkg::RD_CNTM1;
                        end
                    end
                    else
                    begin
                        cmd.wr_sel   = ffha_pkg::WR_USED;
                        cmd.finish   = 1'b1;
                        cmd.addr_sel = ffha_pkg::ADDR_SCAN;
                    end
                end
                else if (sts.last)
                begin
                    cmd.finish = 1'b1;
                    cmd.res    = (sts.op == ffha_pkg::OP_FREE) ? ffha_pkg::ST_UNKNOWN
                                                               : ffha_pkg::ST_NOMEM;
                end
                else
                begin
                    cmd.idx_op = ffha_pkg::IDX_INC;
                    cmd.rd_sel = ffha_pkg::RD_IDX1;
                end
            end
            ffha_pkg::S_FREE_NX:
            begin
                cmd.wr_sel = ffha_pkg::WR_FREE;
                if (sts.merge && sts.shdn_need)
                begin
                    cmd.sp_op  = ffha_pkg::SP_LOAD_IDX1;
                    cmd.rd_sel = ffha_pkg::RD_IDX2;
                end
                else
                begin
                    cmd.cnt_op = sts.merge ? ffha_pkg::CNT_DEC : ffha_pkg::CNT_HOLD;
                    cmd.finish = 1'b1;
                end
            end
            ffha_pkg::S_SHUP:
            begin
                cmd.wr_sel = ffha_pkg::WR_SHIFT;
                cmd.rd_sel = ffha_pkg::RD_SPM2;
                cmd.sp_op  = ffha_pkg::SP_DEC;
            end
            ffha_pkg::S_SPLIT_HI:
            begin
                cmd.wr_sel = ffha_pkg::WR_SPLIT_HI;
            end
            ffha_pkg::S_SPLIT_LO:
            begin
                cmd.wr_sel   = ffha_pkg::WR_SPLIT_LO;
                cmd.cnt_op   = ffha_pkg::CNT_INC;
                cmd.finish   = 1'b1;
                cmd.addr_sel = ffha_pkg::ADDR_SAVED;
            end
            ffha_pkg::S_SHDN:
            begin
                cmd.wr_sel = ffha_pkg::WR_SHIFT;
                cmd.rd_sel = ffha_pkg::RD_SPP2;
                cmd.sp_op  = ffha_pkg::SP_INC;
                if (!sts.shdn_more)
                begin
                    cmd.cnt_op = ffha_pkg::CNT_DEC;
                    cmd.finish = 1'b1;
                end
            end
            default:
            begin
                cmd.finish = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/ffha_datapath.sv
module ffha_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         write_enable,
    input  logic                         register_index,
    input  logic [ffha_pkg::ADDR_W-1:0]  write_data,
    input  logic [1:0]                   opcode,
    input  logic [ffha_pkg::REQ_W-1:0]   request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]  free_address,
    input  ffha_pkg::cmd_t               cmd,
    output ffha_pkg::sts_t               sts,
    output logic                         done,
    output logic [ffha_pkg::ADDR_W-1:0]  address,
    output logic [1:0]                   status
);

    localparam int unsigned IW = ffha_pkg::IDX_W;
    localparam int unsigned CW = ffha_pkg::CNT_W;
    localparam int unsigned SW = ffha_pkg::SIZE_W;
    localparam int unsigned AW = ffha_pkg::ADDR_W;

    // segment table, one write and one registered read per cycle
    ffha_pkg::seg_t seg_mem [ffha_pkg::MAX_SEGMENTS];
    ffha_pkg::seg_t rdata_reg;

    logic [AW-1:0]                heap_base_reg, heap_base_next;
    logic [SW-1:0]                heap_len_reg, heap_len_next;
    logic [CW-1:0]                count_reg, count_next;
    logic                         done_reg, done_next;
    logic [1:0]                   op_reg, op_next;
    logic [ffha_pkg::REQ_W-1:0]   req_reg, req_next;
    logic [AW-1:0]                fa_reg, fa_next;
    logic [IW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                off_reg, off_next;
    logic [CW-1:0]                sp_reg, sp_next;
    logic [SW-1:0]                hit_size_reg, hit_size_next;
    logic [AW-1:0]                grant_reg, grant_next;
    logic [AW-1:0]                address_reg, address_next;
    logic [1:0]                   status_reg, status_next;

    logic [SW-1:0]   need;
    logic [AW-1:0]   scan_addr;
    logic            fit;
    logic [IW-1:0]   raddr;
    logic [IW-1:0]   waddr;
    logic            we;
    ffha_pkg::seg_t  wdata;

    assign need      = (SW'(req_reg) + SW'(3)) & ffha_pkg::ALIGN_MASK;
    assign scan_addr = heap_base_reg + off_reg + AW'(ffha_pkg::HEADER_BYTES);
    assign fit       = rdata_reg.is_free && (rdata_reg.size >= need);

    always_comb
    begin
        sts            = '0;
        sts.op         = op_reg;
        sts.count_zero = (count_reg == '0);
        sts.null_free  = (fa_reg == '0);
        sts.hit        = (op_reg == ffha_pkg::OP_ALLOC) ? fit : (scan_addr == fa_reg);
        sts.last       = ((CW'(idx_reg) + CW'(1)) >= count_reg);
        sts.split      = ({1'b0, rdata_reg.size} >=
                          ({1'b0, need} + (SW+1)'(ffha_pkg::HEADER_BYTES + 4)));
        sts.full       = (count_reg >= CW'(ffha_pkg::MAX_SEGMENTS));
        sts.shift_up   = (count_reg > (CW'(idx_reg) + CW'(1)));
        sts.shup_more  = ((CW+1)'(sp_reg) > ((CW+1)'(idx_reg) + (CW+1)'(2)));
        sts.merge      = !sts.last && rdata_reg.is_free;
        sts.shdn_need  = (((CW+1)'(idx_reg) + (CW+1)'(2)) < (CW+1)'(count_reg));
        sts.shdn_more  = (((CW+1)'(sp_reg) + (CW+1)'(2)) < (CW+1)'(count_reg));
    end

    // read address
    always_comb
    begin
        case (cmd.rd_sel)
            ffha_pkg::RD_ZERO:  raddr = '0;
            ffha_pkg::RD_IDX1:  raddr = idx_reg + IW'(1);
            ffha_pkg::RD_IDX2:  raddr = idx_reg + IW'(2);
            ffha_pkg::RD_CNTM1: raddr = IW'(count_reg - CW'(1));
            ffha_pkg::RD_SPM2:  raddr = IW'(sp_reg - CW'(2));
            ffha_pkg::RD_SPP2:  raddr = IW'(sp_reg + CW'(2));
            default:            raddr = '0;
        endcase
    end

    // write port
    always_comb
    begin
        we    = 1'b1;
        waddr = idx_reg;
        wdata = rdata_reg;
        case (cmd.wr_sel)
            ffha_pkg::WR_INIT:
            begin
                waddr         = '0;
                wdata.is_free = 1'b1;
                wdata.size    = (heap_len_reg > SW'(ffha_pkg::HEADER_BYTES)) ?
                                (heap_len_reg - SW'(ffha_pkg::HEADER_BYTES)) : '0;
            end
            ffha_pkg::WR_USED:
            begin
                wdata.is_free = 1'b0;
            end
            ffha_pkg::WR_SHIFT:
            begin
                waddr = sp_reg[IW-1:0];
            end
            ffha_pkg::WR_SPLIT_HI:
            begin
                waddr         = idx_reg + IW'(1);
                wdata.is_free = 1'b1;
                wdata.size    = hit_size_reg - need - SW'(ffha_pkg::HEADER_BYTES);
            end
            ffha_pkg::WR_SPLIT_LO:
            begin
                wdata.is_free = 1'b0;
                wdata.size    = need;
            end
            ffha_pkg::WR_FREE:
            begin
                // forward merge wraps to the size field width
                wdata.is_free = 1'b1;
                wdata.size    = sts.merge ?
                                (hit_size_reg + rdata_reg.size + SW'(ffha_pkg::HEADER_BYTES)) :
                                hit_size_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            seg_mem[waddr] <= wdata;
        end
        rdata_reg <= seg_mem[raddr];
    end

    always_comb
    begin
        heap_base_next = heap_base_reg;
        heap_len_next  = heap_len_reg;
        if (write_enable)
        begin
            if (register_index == ffha_pkg::REG_HEAP_BASE)
            begin
                heap_base_next = write_data;
            end
            else
            begin
                heap_len_next = write_data[SW-1:0];
            end
        end

        op_next  = op_reg;
        req_next = req_reg;
        fa_next  = fa_reg;
        if (cmd.capture)
        begin
            op_next  = opcode;
            req_next = request_size;
            fa_next  = free_address;
        end

        idx_next = idx_reg;
        off_next = off_reg;
        case (cmd.idx_op)
            ffha_pkg::IDX_CLR:
            begin
                idx_next = '0;
                off_next = '0;
            end
            ffha_pkg::IDX_INC:
            begin
                idx_next = idx_reg + IW'(1);
                off_next = off_reg + AW'(ffha_pkg::HEADER_BYTES) + AW'(rdata_reg.size);
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        case (cmd.sp_op)
            ffha_pkg::SP_LOAD_CNT:  sp_next = count_reg;
            ffha_pkg::SP_LOAD_IDX1: sp_next = CW'(idx_reg) + CW'(1);
            ffha_pkg::SP_DEC:       sp_next = sp_reg - CW'(1);
            ffha_pkg::SP_INC:       sp_next = sp_reg + CW'(1);
            default:                sp_next = sp_reg;
        endcase

        case (cmd.cnt_op)
            ffha_pkg::CNT_ONE: count_next = CW'(1);
            ffha_pkg::CNT_INC: count_next = count_reg + CW'(1);
            ffha_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:           count_next = count_reg;
        endcase

        hit_size_next = hit_size_reg;
        grant_next    = grant_reg;
        if (cmd.save_hit)
        begin
            hit_size_next = rdata_reg.size;
            grant_next    = scan_addr;
        end

        done_next    = cmd.finish;
        address_next = address_reg;
        status_next  = status_reg;
        if (cmd.finish)
        begin
            status_next = cmd.res;
            case (cmd.addr_sel)
                ffha_pkg::ADDR_SCAN:  address_next = scan_addr;
                ffha_pkg::ADDR_SAVED: address_next = grant_reg;
                default:              address_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= AW'(1048576);
            heap_len_reg  <= SW'(65536);
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
            heap_len_reg  <= heap_len_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        req_reg      <= req_next;
        fa_reg       <= fa_next;
        idx_reg      <= idx_next;
        off_reg      <= off_next;
        sp_reg       <= sp_next;
        hit_size_reg <= hit_size_next;
        grant_reg    <= grant_next;
        address_reg  <= address_next;
        status_reg   <= status_next;
    end

    assign done    = done_reg;
    assign address = address_reg;
    assign status  = status_reg;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// first-fit heap allocator with split and forward coalesce
//
// command channel: a transaction is taken at a rising edge with start high
// and busy low; opcode, request_size and free_address are sampled then.
// opcode 0 initialises the heap, 1 allocates, 2 frees a payload address.
// result channel: done is high for exactly one cycle with address and
// status; the receiver cannot stall, so the result is simply presented.
// one result per transaction, and busy is already low while done is shown.
// sequence: init, null free, unused opcode and early failures finish in the
// dispatch state, done following in the cycle after; allocate and free walk
// the segment table one entry per cycle, set by the single read port of the
// table memory; a split then moves later entries up one per cycle, writes the
// upper free part, then the granted part; a free writes the freed entry, then
// a merge moves any later entries down one per cycle; the walk stops at the hit.
// one command at a time. configuration: write_enable, register_index (0 heap
// base, 1 heap length) and write_data, taken at any edge with write_enable
// high; users must write only while idle; the block does not enforce it.
// reset: the segment table is empty (heap not initialised), heap base and
// heap length take their defaults; the table memory itself is not cleared.
module first_fit_heap_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic [ffha_pkg::REQ_W-1:0]   request_size,
    input  logic [ffha_pkg::ADDR_W-1:0]  free_address,
    output logic                         done,
    output logic [ffha_pkg::ADDR_W-1:0]  address,
    output logic [1:0]                   status,
    input  logic                         write_enable,
    input  logic                         register_index,
    input  logic [ffha_pkg::ADDR_W-1:0]  write_data
);

    // command and status between sequencer and table datapath
    ffha_pkg::cmd_t cmd;
    ffha_pkg::sts_t sts;

    // sequencer: dispatch, scan, free, shift and split steps
    ffha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // table memory, address accumulator, config and result registers
    ffha_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .register_index (register_index),
        .write_data     (write_data),
        .opcode         (opcode),
        .request_size   (request_size),
        .free_address   (free_address),
        .cmd            (cmd),
        .sts            (sts),
        .done           (done),
        .address        (address),
        .status         (status)
    );

endmodule

>>> rtl/ffha_checker.sv
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [ffha_pkg::ADDR_W-1:0]  address,
    input logic [1:0]                   status
);

    // accepted transaction keeps the block busy next cycle
    `FFHA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // result only once the block is back to idle
    `FFHA_ASSERT_IMP(a_done_idle, done, !busy && $past(busy))
    // one result per transaction, never two in a row
    `FFHA_ASSERT_NXT(a_done_single, done, !done)
    // a failed transaction grants no address
    `FFHA_ASSERT_IMP(a_fail_zero, done && (status != ffha_pkg::ST_OK), address == '0)
    // busy only drops when the result comes out
    `FFHA_ASSERT_IMP(a_fell_done, $fell(busy), done)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .address (address),
    .status  (status)
);
